// ===== rtl/param_save_scheduler_macros.svh =====
// Assertion macros used by the checker file of the parameter save scheduler.
`ifndef PARAM_SAVE_SCHEDULER_MACROS_SVH
`define PARAM_SAVE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pss_pkg.sv =====
// Types and constants shared by the parameter save scheduler modules.
`default_nettype none

package pss_pkg;

  localparam int unsigned CFG_WIDTH  = 32;
  localparam int unsigned GEN_FIELD  = 16;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [CFG_WIDTH-1:0] RETRY_RESET_MS = 32'd5000;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_NONE   = 2'd3
  } pss_kind_e;

  typedef enum logic [1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_STABLE_DELAY = 2'd1,
    CFG_RETRY_DELAY  = 2'd2
  } pss_cfg_idx_e;

  typedef struct packed {
    pss_kind_e              kind;
    logic                   done_ok;
    logic [GEN_FIELD-1:0]   done_generation;
  } pss_in_t;

  typedef struct packed {
    logic                   save_request;
    logic [GEN_FIELD-1:0]   request_generation;
    logic                   dirty_flag;
    logic                   busy_flag;
    logic                   failed_flag;
    logic [COUNT_WIDTH-1:0] change_total;
    logic [COUNT_WIDTH-1:0] save_total;
  } pss_out_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] min_save_interval_ms;
    logic [CFG_WIDTH-1:0] stable_delay_ms;
    logic [CFG_WIDTH-1:0] retry_wait_ms;
  } pss_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pss_cfg.sv =====
// Configuration register file of the parameter save scheduler.
`default_nettype none

module pss_cfg
  import pss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata_i,
  output pss_cfg_t                  cfg_o
);

  pss_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_INTERVAL: cfg_d.min_save_interval_ms = cfg_wdata_i;
        CFG_STABLE_DELAY: cfg_d.stable_delay_ms      = cfg_wdata_i;
        CFG_RETRY_DELAY:  cfg_d.retry_wait_ms        = cfg_wdata_i;
        default:          cfg_d                      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_save_interval_ms <= '0;
      cfg_q.stable_delay_ms      <= '0;
      cfg_q.retry_wait_ms        <= RETRY_RESET_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/pss_core.sv =====
// Scheduler state and the per-transaction update logic.
`default_nettype none

module pss_core
  import pss_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned GEN_WIDTH  = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire pss_in_t  item_i,
  input  wire pss_cfg_t cfg_i,
  output pss_out_t      res_o
);

  localparam int unsigned CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  logic                   dirty_q, dirty_d;
  logic                   busy_q, busy_d;
  logic                   failed_q, failed_d;
  logic [GEN_WIDTH-1:0]   gen_q, gen_d;
  logic [COUNT_WIDTH-1:0] chg_cnt_q, chg_cnt_d;
  logic [COUNT_WIDTH-1:0] save_cnt_q, save_cnt_d;
  logic [TIME_WIDTH-1:0]  ms_chg_q, ms_chg_d;
  logic [TIME_WIDTH-1:0]  ms_save_q, ms_save_d;
  logic [TIME_WIDTH-1:0]  ms_fail_q, ms_fail_d;

  logic [TIME_WIDTH-1:0]  ms_chg_inc, ms_save_inc, ms_fail_inc;
  logic                   interval_ok, stable_ok, retry_ok;
  logic                   req;

  assign ms_chg_inc  = (&ms_chg_q)  ? ms_chg_q  : ms_chg_q  + 1'b1;
  assign ms_save_inc = (&ms_save_q) ? ms_save_q : ms_save_q + 1'b1;
  assign ms_fail_inc = (&ms_fail_q) ? ms_fail_q : ms_fail_q + 1'b1;

  assign interval_ok = (save_cnt_q == '0) ||
                       (CMP_WIDTH'(ms_save_inc) >= CMP_WIDTH'(cfg_i.min_save_interval_ms));
  assign stable_ok   = CMP_WIDTH'(ms_chg_inc) >= CMP_WIDTH'(cfg_i.stable_delay_ms);
  assign retry_ok    = !failed_q ||
                       (CMP_WIDTH'(ms_fail_inc) >= CMP_WIDTH'(cfg_i.retry_wait_ms));

  always_comb begin
    dirty_d    = dirty_q;
    busy_d     = busy_q;
    failed_d   = failed_q;
    gen_d      = gen_q;
    chg_cnt_d  = chg_cnt_q;
    save_cnt_d = save_cnt_q;
    ms_chg_d   = ms_chg_q;
    ms_save_d  = ms_save_q;
    ms_fail_d  = ms_fail_q;
    req        = 1'b0;
    unique case (item_i.kind)
      KIND_TICK: begin
        ms_chg_d  = ms_chg_inc;
        ms_save_d = ms_save_inc;
        ms_fail_d = ms_fail_inc;
        if (dirty_q && !busy_q && interval_ok && stable_ok && retry_ok) begin
          req    = 1'b1;
          busy_d = 1'b1;
        end
      end
      KIND_CHANGE: begin
        chg_cnt_d = chg_cnt_q + 1'b1;
        gen_d     = gen_q + 1'b1;
        dirty_d   = 1'b1;
        ms_chg_d  = '0;
      end
      KIND_DONE: begin
        if (busy_q) begin
          busy_d = 1'b0;
          if (!item_i.done_ok) begin
            failed_d  = 1'b1;
            dirty_d   = 1'b1;
            ms_fail_d = '0;
          end else begin
            failed_d   = 1'b0;
            ms_save_d  = '0;
            save_cnt_d = save_cnt_q + 1'b1;
            if (GEN_WIDTH'(item_i.done_generation) == gen_q) begin
              dirty_d = 1'b0;
            end
          end
        end
      end
      KIND_NONE: begin
        req = 1'b0;
      end
      default: begin
        req = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.save_request       = req;
    res_o.request_generation = req ? GEN_FIELD'(gen_q) : '0;
    res_o.dirty_flag         = dirty_d;
    res_o.busy_flag          = busy_d;
    res_o.failed_flag        = failed_d;
    res_o.change_total       = chg_cnt_d;
    res_o.save_total         = save_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q    <= 1'b0;
      busy_q     <= 1'b0;
      failed_q   <= 1'b0;
      gen_q      <= '0;
      chg_cnt_q  <= '0;
      save_cnt_q <= '0;
      ms_chg_q   <= '0;
      ms_save_q  <= '0;
      ms_fail_q  <= '0;
    end else if (fire_i) begin
      dirty_q    <= dirty_d;
      busy_q     <= busy_d;
      failed_q   <= failed_d;
      gen_q      <= gen_d;
      chg_cnt_q  <= chg_cnt_d;
      save_cnt_q <= save_cnt_d;
      ms_chg_q   <= ms_chg_d;
      ms_save_q  <= ms_save_d;
      ms_fail_q  <= ms_fail_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/param_save_scheduler.sv =====
// Top level of the parameter save scheduler.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one transaction per event:
// a one-millisecond tick, a parameter change, or a save completion with its status and
// the generation tag that the finished save carried.
// The output channel (out_valid_o, out_ready_i, out_data_o) returns exactly one result
// transaction per input transaction, in order: whether a save starts now, its generation
// tag, the dirty, busy and failed flags, and the change and save totals.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the
// user must write them only while no transaction is in flight, as the block does not enforce it.
// An accepted transaction is held in the input register, then the state update and the
// result are computed and captured in the result register, from which the receiver takes
// it. One transaction is accepted every cycle while the receiver does not stall; the rate
// is set by the combinational state update between the two registers.
// When the receiver stalls, the result register holds its contents and the input register
// keeps the next transaction, so in_ready_o drops only while both are full.
// Reset clears all flags, counters and elapsed-time counters, sets the retry delay to
// 5000 ms and the other delays to zero, and empties both registers.
`default_nettype none

module param_save_scheduler
  import pss_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned GEN_WIDTH  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pss_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output pss_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  logic     in_valid_q, in_valid_d;
  pss_in_t  in_item_q;
  logic     out_valid_q, out_valid_d;
  pss_out_t out_data_q;
  logic     advance;
  logic     fire;
  pss_cfg_t cfg;
  pss_out_t res;

  pss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pss_core #(
    .TIME_WIDTH (TIME_WIDTH),
    .GEN_WIDTH  (GEN_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/pss_checker.sv =====
// Port-level checker for the parameter save scheduler, bound to the top level.
`default_nettype none

`include "param_save_scheduler_macros.svh"

module pss_checker
  import pss_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire pss_out_t out_data_o
);

  `PSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "Stalled result transaction changed or vanished.")
  `PSS_ASSERT_IMP(a_backpressure, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "Input stalled while the result side could move.")
  `PSS_ASSERT_IMP(a_request_flags, clk_i, rst_ni, out_valid_o && out_data_o.save_request, out_data_o.busy_flag && out_data_o.dirty_flag, "Save request without busy and dirty set.")
  `PSS_ASSERT_IMP(a_idle_generation, clk_i, rst_ni, out_valid_o && !out_data_o.save_request, out_data_o.request_generation == '0, "Generation tag shown without a save request.")

endmodule

bind param_save_scheduler pss_checker u_pss_checker (.*);

`default_nettype wire
